@@ src/climate_relay_hysteresis_control_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Climate relay hysteresis control: assertion macros
// Shared concurrent assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef CLIMATE_RELAY_HYSTERESIS_CONTROL_UNIT_MACROS_SVH
`define CLIMATE_RELAY_HYSTERESIS_CONTROL_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CRHC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crhc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CRHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crhc: next-cycle check failed");

`endif

@@ src/crhc_pkg.sv @@
// ----------------------------------------------------------------------------
// Climate relay hysteresis control: package
// Types, register indexes, reset values and command codes.
// ----------------------------------------------------------------------------
package crhc_pkg;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_AUTO_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SAFE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CO2_MAX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CO2_SAFE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_SAFE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_LIMITS  = 3'd7;

  localparam logic               RST_AUTO_ENABLE   = 1'b1;
  localparam logic signed [11:0] RST_TEMP_MAX      = 12'sd300;
  localparam logic signed [11:0] RST_TEMP_SAFE     = 12'sd280;
  localparam logic [15:0]        RST_CO2_MAX       = 16'd1000;
  localparam logic [15:0]        RST_CO2_SAFE      = 16'd800;
  localparam logic [9:0]         RST_HUMIDITY_MAX  = 10'd750;
  localparam logic [9:0]         RST_HUMIDITY_SAFE = 10'd700;
  localparam logic [15:0]        RST_LIGHT_MIN     = 16'd1000;
  localparam logic [15:0]        RST_LIGHT_MAX     = 16'd1500;

  localparam logic signed [11:0] COOLER_SETPOINT  = 12'sd240;
  localparam logic signed [11:0] COOLER_OFF_CODE  = -12'sd10;
  localparam logic signed [11:0] COOLER_NO_CMD    = 12'sd0;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_MANUAL = 1'b1;

  localparam logic SEL_RELAY_ONE = 1'b0;
  localparam logic SEL_RELAY_TWO = 1'b1;

  typedef struct packed {
    logic               auto_enable;
    logic signed [11:0] temp_hi;
    logic signed [11:0] temp_lo;
    logic [15:0]        co2_hi;
    logic [15:0]        co2_lo;
    logic [9:0]         hum_hi;
    logic [9:0]         hum_lo;
    logic [15:0]        lux_lo;
    logic [15:0]        lux_hi;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic signed [11:0] temperature;
    logic [9:0]         humidity_level;
    logic [15:0]        co2_level;
    logic [15:0]        light_level;
    logic               relay_select;
    logic               relay_value;
  } item_t;

  typedef struct packed {
    logic               relay_one_on;
    logic               relay_two_on;
    logic               cooler_on;
    logic               cooler_send;
    logic signed [11:0] cooler_setpoint;
  } res_t;

endpackage

@@ src/crhc_in_if.sv @@
// ----------------------------------------------------------------------------
// Climate relay hysteresis control: input channel
// Valid/ready channel carrying one sensor sample or manual relay request.
// ----------------------------------------------------------------------------
interface crhc_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [11:0] temperature;
  logic [9:0]         humidity_level;
  logic [15:0]        co2_level;
  logic [15:0]        light_level;
  logic               relay_select;
  logic               relay_value;

  modport source (
    output valid, cmd, temperature, humidity_level, co2_level, light_level,
           relay_select, relay_value,
    input  ready
  );

  modport sink (
    input  valid, cmd, temperature, humidity_level, co2_level, light_level,
           relay_select, relay_value,
    output ready
  );
endinterface

@@ src/crhc_out_if.sv @@
// ----------------------------------------------------------------------------
// Climate relay hysteresis control: result channel
// Valid/ready channel carrying the relay and cooler state after each request.
// ----------------------------------------------------------------------------
interface crhc_out_if;
  logic               valid;
  logic               ready;
  logic               relay_one_on;
  logic               relay_two_on;
  logic               cooler_on;
  logic               cooler_send;
  logic signed [11:0] cooler_setpoint;

  modport source (
    output valid, relay_one_on, relay_two_on, cooler_on, cooler_send, cooler_setpoint,
    input  ready
  );

  modport sink (
    input  valid, relay_one_on, relay_two_on, cooler_on, cooler_send, cooler_setpoint,
    output ready
  );
endinterface

@@ src/crhc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Climate relay hysteresis control: configuration registers
// Holds the mode bit and all thresholds, written through a plain write port.
// ----------------------------------------------------------------------------
module crhc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [crhc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [crhc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output crhc_pkg::cfg_t                 cfg
);

  crhc_pkg::cfg_t cfg_r;
  crhc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        crhc_pkg::REG_AUTO_ENABLE:   cfg_nxt.auto_enable = cfg_wdata[0];
        crhc_pkg::REG_TEMP_MAX:      cfg_nxt.temp_hi     = $signed(cfg_wdata[11:0]);
        crhc_pkg::REG_TEMP_SAFE:     cfg_nxt.temp_lo     = $signed(cfg_wdata[11:0]);
        crhc_pkg::REG_CO2_MAX:       cfg_nxt.co2_hi      = cfg_wdata[15:0];
        crhc_pkg::REG_CO2_SAFE:      cfg_nxt.co2_lo      = cfg_wdata[15:0];
        crhc_pkg::REG_HUMIDITY_MAX:  cfg_nxt.hum_hi      = cfg_wdata[9:0];
        crhc_pkg::REG_HUMIDITY_SAFE: cfg_nxt.hum_lo      = cfg_wdata[9:0];
        crhc_pkg::REG_LIGHT_LIMITS: begin
          cfg_nxt.lux_lo = cfg_wdata[15:0];
          cfg_nxt.lux_hi = cfg_wdata[31:16];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_enable <= crhc_pkg::RST_AUTO_ENABLE;
      cfg_r.temp_hi     <= crhc_pkg::RST_TEMP_MAX;
      cfg_r.temp_lo     <= crhc_pkg::RST_TEMP_SAFE;
      cfg_r.co2_hi      <= crhc_pkg::RST_CO2_MAX;
      cfg_r.co2_lo      <= crhc_pkg::RST_CO2_SAFE;
      cfg_r.hum_hi      <= crhc_pkg::RST_HUMIDITY_MAX;
      cfg_r.hum_lo      <= crhc_pkg::RST_HUMIDITY_SAFE;
      cfg_r.lux_lo      <= crhc_pkg::RST_LIGHT_MIN;
      cfg_r.lux_hi      <= crhc_pkg::RST_LIGHT_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/crhc_rule_core.sv @@
// ----------------------------------------------------------------------------
// Climate relay hysteresis control: rule core
// Holds the relay and cooler states and applies one request to them.
// ----------------------------------------------------------------------------
module crhc_rule_core #(
  parameter logic signed [11:0] COOLER_SETPOINT = crhc_pkg::COOLER_SETPOINT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  crhc_pkg::item_t item,
  input  crhc_pkg::cfg_t  cfg,
  output crhc_pkg::res_t  res
);

  logic relay_one_r, relay_one_nxt;
  logic relay_two_r, relay_two_nxt;
  logic cooler_r, cooler_nxt;
  logic send;

  logic temp_above_max;
  logic temp_below_safe;
  logic co2_above_max;
  logic co2_below_safe;
  logic hum_above_max;
  logic hum_below_safe;
  logic light_above_max;
  logic light_below_min;

  assign temp_above_max  = $signed(item.temperature) > $signed(cfg.temp_hi);
  assign temp_below_safe = $signed(item.temperature) < $signed(cfg.temp_lo);
  assign co2_above_max   = item.co2_level > cfg.co2_hi;
  assign co2_below_safe  = item.co2_level < cfg.co2_lo;
  assign hum_above_max   = item.humidity_level > cfg.hum_hi;
  assign hum_below_safe  = item.humidity_level < cfg.hum_lo;
  assign light_above_max = item.light_level > cfg.lux_hi;
  assign light_below_min = item.light_level < cfg.lux_lo;

  always_comb begin
    relay_one_nxt = relay_one_r;
    relay_two_nxt = relay_two_r;
    cooler_nxt    = cooler_r;
    send          = 1'b0;
    if (item.cmd == crhc_pkg::CMD_MANUAL) begin
      if (item.relay_select == crhc_pkg::SEL_RELAY_TWO) begin
        relay_two_nxt = item.relay_value;
      end else begin
        relay_one_nxt = item.relay_value;
      end
    end else if (cfg.auto_enable) begin
      if (temp_above_max && !cooler_r) begin
        cooler_nxt = 1'b1;
        send       = 1'b1;
      end else if (temp_below_safe && cooler_r) begin
        cooler_nxt = 1'b0;
        send       = 1'b1;
      end

      if (co2_above_max) begin
        relay_one_nxt = 1'b1;
        relay_two_nxt = 1'b1;
      end else begin
        if (light_above_max && relay_one_r) begin
          relay_one_nxt = 1'b0;
        end else if (light_below_min && !relay_one_r) begin
          relay_one_nxt = 1'b1;
        end
        if (hum_below_safe && relay_two_r) begin
          relay_two_nxt = 1'b0;
        end else if (hum_above_max && !relay_two_r) begin
          relay_two_nxt = 1'b1;
        end
        if (co2_below_safe && !temp_above_max && !hum_above_max) begin
          relay_one_nxt = 1'b0;
          relay_two_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res.relay_one_on = relay_one_nxt;
    res.relay_two_on = relay_two_nxt;
    res.cooler_on    = cooler_nxt;
    res.cooler_send  = send;
    if (!send) begin
      res.cooler_setpoint = crhc_pkg::COOLER_NO_CMD;
    end else if (cooler_nxt) begin
      res.cooler_setpoint = COOLER_SETPOINT;
    end else begin
      res.cooler_setpoint = crhc_pkg::COOLER_OFF_CODE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_one_r <= 1'b1;
      relay_two_r <= 1'b1;
      cooler_r    <= 1'b0;
    end else if (step) begin
      relay_one_r <= relay_one_nxt;
      relay_two_r <= relay_two_nxt;
      cooler_r    <= cooler_nxt;
    end
  end

endmodule

@@ src/climate_relay_hysteresis_control_unit.sv @@
// ----------------------------------------------------------------------------
// Climate relay hysteresis control unit
// Input register, rule core and result register for relay and cooler control.
// ----------------------------------------------------------------------------
// A request accepted at a clock edge is held in the input register, passes
// through the rule core into the result register once that register is free
// or being taken, and is presented as a valid result from then on. A new
// request is accepted every cycle as long as the result side takes its
// results, since the relay and cooler states are updated in place as each
// request leaves the input register; while a result waits, one more request
// is held and the input stalls. Thresholds are to be written through the cfg_
// port only while no request is in flight; the block itself does not enforce
// this.
module climate_relay_hysteresis_control_unit #(
  parameter logic signed [11:0] COOLER_SETPOINT = crhc_pkg::COOLER_SETPOINT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  crhc_in_if.sink                         in_ch,
  crhc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [crhc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [crhc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  `include "climate_relay_hysteresis_control_unit_macros.svh"

  crhc_pkg::cfg_t  cfg;
  crhc_pkg::item_t item_r;
  crhc_pkg::res_t  res;
  crhc_pkg::res_t  res_r;
  logic            in_vld_r;
  logic            out_vld_r;
  logic            advance;
  logic            in_take;
  logic            out_quiet;
  logic            out_sends;
  logic            sp_matches;

  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  crhc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  crhc_rule_core #(
    .COOLER_SETPOINT (COOLER_SETPOINT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.cmd            <= in_ch.cmd;
      item_r.temperature    <= in_ch.temperature;
      item_r.humidity_level <= in_ch.humidity_level;
      item_r.co2_level      <= in_ch.co2_level;
      item_r.light_level    <= in_ch.light_level;
      item_r.relay_select   <= in_ch.relay_select;
      item_r.relay_value    <= in_ch.relay_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.relay_one_on    = res_r.relay_one_on;
  assign out_ch.relay_two_on    = res_r.relay_two_on;
  assign out_ch.cooler_on       = res_r.cooler_on;
  assign out_ch.cooler_send     = res_r.cooler_send;
  assign out_ch.cooler_setpoint = res_r.cooler_setpoint;

  assign out_quiet  = out_vld_r && !res_r.cooler_send;
  assign out_sends  = out_vld_r && res_r.cooler_send;
  assign sp_matches = res_r.cooler_on ? (res_r.cooler_setpoint == COOLER_SETPOINT) :
                      (res_r.cooler_setpoint == crhc_pkg::COOLER_OFF_CODE);

  `CRHC_ASSERT_IMPLIES(a_no_cmd_zero, clk, rst_n, out_quiet, res_r.cooler_setpoint == 12'sd0)
  `CRHC_ASSERT_IMPLIES(a_cmd_matches_state, clk, rst_n, out_sends, sp_matches)
  `CRHC_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_vld_r)

endmodule
